>>> sv/sn2o_pkg.sv
// Shared constants, types and the permutation table of the 2D simplex octave noise block.
`default_nettype none
package sn2o_pkg;

  // Number of octaves summed for every sample.
  localparam int OCTAVES = 4;
  localparam int OCT_IDX_W = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;

  // Register stages from the input request to the output register.
  localparam int NSTG = 13;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_FREQUENCY = 3'd0,
    REG_BASE_AMPLITUDE = 3'd1,
    REG_LACUNARITY     = 3'd2,
    REG_PERSISTENCE    = 3'd3,
    REG_SEED_OFFSET    = 3'd4
  } cfg_reg_t;

  // Reset values of the registers.
  localparam logic [23:0] RST_FREQUENCY   = 24'd65536;
  localparam logic [23:0] RST_AMPLITUDE   = 24'd65536;
  localparam logic [19:0] RST_LACUNARITY  = 20'd131072;
  localparam logic [16:0] RST_PERSISTENCE = 17'd32768;
  localparam logic [15:0] RST_SEED        = 16'd0;

  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  // Skew and unskew factors in Q0.16.
  localparam logic signed [15:0] SKEW_F2   = 16'sd23988;
  localparam logic signed [15:0] UNSKEW_G2 = 16'sd13849;

  // Largest corner offset magnitude whose square can still leave a positive falloff.
  localparam int OFS_LIMIT = 46340;

  // Control that travels from the top level into each octave lane.
  typedef struct packed {
    logic [NSTG:1] en;
  } pipe_ctl_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,
    8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,
    8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,
    8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,
    8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,
    8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,
    8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,
    8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
    return PERM[idx];
  endfunction

endpackage
`default_nettype wire

>>> sv/sn2o_ifs.sv
// Request channel interfaces of the 2D simplex octave noise block.
`default_nettype none
interface sn2o_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface sn2o_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

interface sn2o_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sn2o_pkg::CFG_IDX_W-1:0]   index;
  logic [sn2o_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/sn2o_octave.sv
// One octave lane: scaling, skew, cell search, three corner falloffs and amplitude weighting.
`default_nettype none
module sn2o_octave (
  input  wire                        clk,
  input  sn2o_pkg::pipe_ctl_t        ctl,
  input  wire logic signed [32:0]    px,
  input  wire logic signed [32:0]    py,
  input  wire logic [23:0]           freq,
  input  wire logic [23:0]           amp,
  output logic signed [27:0]         na
);
  import sn2o_pkg::*;

  // Gradient dot product selected by the low hash bits.
  function automatic logic signed [18:0] gradient(input logic [7:0] h,
                                                  input logic signed [16:0] dx,
                                                  input logic signed [16:0] dy);
    logic signed [18:0] u;
    logic signed [18:0] v;
    logic signed [18:0] a;
    logic signed [18:0] b;
    u = (h[5:2] == 4'd0) ? 19'(dx) : 19'(dy);
    v = (h[5:2] == 4'd0) ? 19'(dy) : 19'(dx);
    a = h[0] ? -u : u;
    b = h[1] ? -(v <<< 1) : (v <<< 1);
    return a + b;
  endfunction

  // Stage 2: scaled point.
  logic signed [57:0] mx, my;
  logic signed [40:0] x2, y2;
  // Stage 3: skew sum.
  logic signed [41:0] sxy;
  logic signed [57:0] ms;
  logic signed [40:0] x3, y3, s3;
  // Stage 4: cell index and fraction before unskew.
  logic signed [41:0] xs, ys;
  logic signed [25:0] i4, j4;
  logic signed [42:0] xf4, yf4;
  // Stage 5: unskewed corner-zero offset.
  logic signed [26:0] ij;
  logic signed [41:0] tg;
  logic signed [44:0] x5, y5;
  logic [7:0]         i5, j5;
  // Stage 6: corner offsets and corner cell indexes.
  logic               i1;
  logic signed [45:0] d6x [3];
  logic signed [45:0] d6y [3];
  logic [7:0]         ic6 [3];
  logic [7:0]         jc6 [3];
  logic signed [45:0] dx6 [3];
  logic signed [45:0] dy6 [3];
  logic [7:0]         ci6 [3];
  logic [7:0]         cj6 [3];
  // Stage 7: range check, first hash level.
  logic               ok7 [3];
  logic signed [16:0] dx7 [3];
  logic signed [16:0] dy7 [3];
  logic [7:0]         pj7 [3];
  logic [7:0]         ic7 [3];
  // Stage 8: squares and gradient.
  logic signed [33:0] sqx [3];
  logic signed [33:0] sqy [3];
  logic               ok8 [3];
  logic [17:0]        a8 [3];
  logic [17:0]        b8 [3];
  logic signed [18:0] g8 [3];
  // Stage 9: falloff squared.
  logic signed [18:0] t9 [3];
  logic [31:0]        p9 [3];
  logic [14:0]        t2 [3];
  logic signed [18:0] g9 [3];
  // Stage 10: falloff to the fourth.
  logic [29:0]        p10 [3];
  logic [12:0]        t4 [3];
  logic signed [18:0] g10 [3];
  // Stage 11: corner contribution.
  logic signed [32:0] p11 [3];
  logic signed [16:0] c11 [3];
  // Stage 12: octave sum weighted by amplitude.
  logic signed [18:0] n12;
  logic signed [43:0] p12;

  always_comb begin
    mx  = px * $signed({1'b0, freq});
    my  = py * $signed({1'b0, freq});
    sxy = 42'(x2) + 42'(y2);
    ms  = sxy * SKEW_F2;
    xs  = 42'(x3) + 42'(s3);
    ys  = 42'(y3) + 42'(s3);
    ij  = 27'(i4) + 27'(j4);
    tg  = ij * $signed(UNSKEW_G2[14:0]);
    i1  = (x5 > y5);
    d6x[0] = 46'(x5);
    d6y[0] = 46'(y5);
    d6x[1] = 46'(x5) - (i1 ? 46'sd65536 : 46'sd0) + 46'(UNSKEW_G2);
    d6y[1] = 46'(y5) - (i1 ? 46'sd0 : 46'sd65536) + 46'(UNSKEW_G2);
    d6x[2] = 46'(x5) - 46'sd65536 + 46'(UNSKEW_G2) + 46'(UNSKEW_G2);
    d6y[2] = 46'(y5) - 46'sd65536 + 46'(UNSKEW_G2) + 46'(UNSKEW_G2);
    ic6[0] = i5;
    ic6[1] = i5 + {7'd0, i1};
    ic6[2] = i5 + 8'd1;
    jc6[0] = j5;
    jc6[1] = j5 + {7'd0, ~i1};
    jc6[2] = j5 + 8'd1;
    for (int c = 0; c < 3; c++) begin
      sqx[c] = dx7[c] * dx7[c];
      sqy[c] = dy7[c] * dy7[c];
      t9[c]  = 19'sd32768 - $signed({1'b0, a8[c]}) - $signed({1'b0, b8[c]});
      p9[c]  = t9[c][15:0] * t9[c][15:0];
      p10[c] = t2[c] * t2[c];
      p11[c] = $signed({1'b0, t4[c]}) * g10[c];
    end
    n12 = 19'(c11[0]) + 19'(c11[1]) + 19'(c11[2]);
    p12 = n12 * $signed({1'b0, amp});
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      x2 <= 41'(mx >>> 16);
      y2 <= 41'(my >>> 16);
    end
    if (ctl.en[3]) begin
      x3 <= x2;
      y3 <= y2;
      s3 <= 41'(ms >>> 16);
    end
    if (ctl.en[4]) begin
      i4  <= xs[41:16];
      j4  <= ys[41:16];
      xf4 <= $signed({27'd0, xs[15:0]}) - 43'(s3);
      yf4 <= $signed({27'd0, ys[15:0]}) - 43'(s3);
    end
    if (ctl.en[5]) begin
      x5 <= 45'(xf4) + 45'(tg);
      y5 <= 45'(yf4) + 45'(tg);
      i5 <= i4[7:0];
      j5 <= j4[7:0];
    end
    for (int c = 0; c < 3; c++) begin
      if (ctl.en[6]) begin
        dx6[c] <= d6x[c];
        dy6[c] <= d6y[c];
        ci6[c] <= ic6[c];
        cj6[c] <= jc6[c];
      end
      if (ctl.en[7]) begin
        // Offsets beyond the limit always give a non-positive falloff.
        ok7[c] <= (dx6[c] >= -46'(OFS_LIMIT)) && (dx6[c] <= 46'(OFS_LIMIT)) &&
                  (dy6[c] >= -46'(OFS_LIMIT)) && (dy6[c] <= 46'(OFS_LIMIT));
        dx7[c] <= dx6[c][16:0];
        dy7[c] <= dy6[c][16:0];
        pj7[c] <= perm_lookup(cj6[c]);
        ic7[c] <= ci6[c];
      end
      if (ctl.en[8]) begin
        ok8[c] <= ok7[c];
        a8[c]  <= sqx[c][33:16];
        b8[c]  <= sqy[c][33:16];
        g8[c]  <= gradient(perm_lookup(ic7[c] + pj7[c]), dx7[c], dy7[c]);
      end
      if (ctl.en[9]) begin
        t2[c] <= (ok8[c] && (t9[c] > 19'sd0)) ? p9[c][30:16] : 15'd0;
        g9[c] <= g8[c];
      end
      if (ctl.en[10]) begin
        t4[c]  <= p10[c][28:16];
        g10[c] <= g9[c];
      end
      if (ctl.en[11]) begin
        c11[c] <= p11[c][32:16];
      end
    end
    if (ctl.en[12]) begin
      na <= p12[43:16];
    end
  end

endmodule
`default_nettype wire

>>> sv/simplex_noise_2d_octaves.sv
// Top level of the four-octave 2D simplex fractal noise generator.
// Pipeline: 13 register stages; a result is offered once its accepted sample request has
// passed through all of them, and is held there while the output is stalled.
// Throughput: one sample per cycle unless the output stalls or the table is rebuilding;
// a sample enters while earlier ones are still in flight. After reset and after every
// configuration write, a per-octave frequency and amplitude table is rebuilt one octave
// per cycle through one multiplier pair; sample requests are held off during that time.
// Reset (synchronous, active high) clears the valid bits and restores the register defaults.
`default_nettype none
module simplex_noise_2d_octaves (
  input wire              clk,
  input wire              rst,
  sn2o_sample_if.sink     sample,
  sn2o_result_if.source   result,
  sn2o_cfg_if.sink        cfg
);
  import sn2o_pkg::*;

  // Configuration registers. Entry zero of each table is the written base value;
  // the later entries are derived from it by the table update sequence.
  logic [23:0]          freq_tab [OCTAVES];
  logic [23:0]          amp_tab [OCTAVES];
  logic [19:0]          lacunarity;
  logic [16:0]          persistence;
  logic signed [15:0]   seed_offset;

  logic                 busy;
  logic [OCT_IDX_W-1:0] upd_idx;
  logic [OCT_IDX_W-1:0] prev_idx;
  logic [43:0]          freq_prod;
  logic [40:0]          amp_prod;
  logic [23:0]          freq_next;
  logic [23:0]          amp_next;

  // Pipeline control: a valid bit per stage and a stage enable that lets a stage load
  // whenever it is empty or the stage after it moves, so bubbles close up under a stall.
  logic [NSTG:1]        v;
  logic [NSTG-1:0]      vin;
  pipe_ctl_t            ctl;

  logic signed [32:0]   px, py;
  logic signed [27:0]   na [OCTAVES];
  logic signed [33:0]   total;
  logic signed [31:0]   noise;

  assign cfg.ready = 1'b1;

  // Table update: each step multiplies the previous octave's values and saturates them.
  always_comb begin
    prev_idx  = upd_idx - OCT_IDX_W'(1);
    freq_prod = freq_tab[prev_idx] * lacunarity;
    amp_prod  = amp_tab[prev_idx] * persistence;
    freq_next = (freq_prod[43:16] > 28'(MAX24)) ? MAX24 : freq_prod[39:16];
    amp_next  = (amp_prod[40:16] > 25'(MAX24)) ? MAX24 : amp_prod[39:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_tab[0]  <= RST_FREQUENCY;
      amp_tab[0]   <= RST_AMPLITUDE;
      lacunarity   <= RST_LACUNARITY;
      persistence  <= RST_PERSISTENCE;
      seed_offset  <= RST_SEED;
      busy         <= (OCTAVES > 1);
      upd_idx      <= OCT_IDX_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_BASE_FREQUENCY: freq_tab[0] <= cfg.data[23:0];
        REG_BASE_AMPLITUDE: amp_tab[0] <= cfg.data[23:0];
        REG_LACUNARITY:     lacunarity <= cfg.data[19:0];
        REG_PERSISTENCE:    persistence <= cfg.data[16:0];
        REG_SEED_OFFSET:    seed_offset <= cfg.data[15:0];
        default: begin
        end
      endcase
      busy    <= (OCTAVES > 1);
      upd_idx <= OCT_IDX_W'(1);
    end else if (busy) begin
      freq_tab[upd_idx] <= freq_next;
      amp_tab[upd_idx]  <= amp_next;
      if (upd_idx == OCT_IDX_W'(OCTAVES - 1)) begin
        busy <= 1'b0;
      end else begin
        upd_idx <= upd_idx + OCT_IDX_W'(1);
      end
    end
  end

  // Stage enables, computed from the output backward.
  always_comb begin
    ctl.en[NSTG] = !v[NSTG] || result.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      ctl.en[k] = !v[k] || ctl.en[k+1];
    end
  end

  assign sample.ready = ctl.en[1] && !busy;
  assign vin = {v[NSTG-1:1], sample.valid && !busy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (ctl.en[k]) begin
          v[k] <= vin[k-1];
        end
      end
    end
  end

  // Stage 1: the seed, an integer, shifts both coordinates by whole units.
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      px <= 33'(sample.x_coord) + 33'($signed({seed_offset, 16'd0}));
      py <= 33'(sample.y_coord) + 33'($signed({seed_offset, 16'd0}));
    end
  end

  // Stages 2 to 12: one lane per octave, all in lockstep.
  for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
    sn2o_octave u_oct (
      .clk  (clk),
      .ctl  (ctl),
      .px   (px),
      .py   (py),
      .freq (freq_tab[o]),
      .amp  (amp_tab[o]),
      .na   (na[o])
    );
  end

  // Stage 13: the octave sum, clamped to the signed 32-bit range, in the output register.
  always_comb begin
    total = '0;
    for (int o = 0; o < OCTAVES; o++) begin
      total = total + 34'(na[o]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[NSTG]) begin
      if (total > 34'sh07FFFFFFF) begin
        noise <= 32'sh7FFFFFFF;
      end else if (total < -34'sh080000000) begin
        noise <= 32'sh80000000;
      end else begin
        noise <= total[31:0];
      end
    end
  end

  assign result.valid       = v[NSTG];
  assign result.noise_value = noise;

  // No sample request is taken while the octave table is being rebuilt.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !sample.ready)
    else $error("sample request accepted during table update");

  // A configuration write always restarts the table update.
  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready && (OCTAVES > 1)) |=> busy)
    else $error("table update not started after configuration write");

  // A finished result that is not taken stays in the output stage.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (v[NSTG] && !result.ready) |=> v[NSTG])
    else $error("pending result lost");

  // An accepted sample always occupies the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> v[1])
    else $error("accepted sample not in first stage");

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench of the four-octave 2D simplex noise block.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import sn2o_pkg::*;

  // Scoreboard: keeps a copy of the registers, predicts the noise of every
  // accepted sample and compares results in order.
  class noise_scoreboard;
    longint unsigned frequency = RST_FREQUENCY;
    longint unsigned amplitude = RST_AMPLITUDE;
    longint unsigned lacunarity = RST_LACUNARITY;
    longint unsigned persistence = RST_PERSISTENCE;
    longint seed = 0;
    int expected_noise[$];
    int errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE_FREQUENCY: frequency = data;
        REG_BASE_AMPLITUDE: amplitude = data;
        REG_LACUNARITY: lacunarity = data[19:0];
        REG_PERSISTENCE: persistence = data[16:0];
        REG_SEED_OFFSET: seed = longint'($signed(data[15:0]));
        default: ;
      endcase
    endfunction

    function longint corner_term(longint ci, longint cj, longint dx, longint dy);
      longint t;
      longint u;
      longint v;
      longint g;
      logic [7:0] hidx;
      logic [7:0] h;
      t = 64'sd32768 - ((dx * dx) >>> 16) - ((dy * dy) >>> 16);
      if (t <= 0) return 0;
      t = (t * t) >>> 16;
      t = (t * t) >>> 16;
      // Only the low byte of each cell index takes part in the hash.
      hidx = ci[7:0] + PERM[cj[7:0]];
      h = PERM[hidx] & 8'h3F;
      u = (h < 4) ? dx : dy;
      v = (h < 4) ? dy : dx;
      g = (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
      return (t * g) >>> 16;
    endfunction

    function int fractal_noise(logic signed [31:0] x, logic signed [31:0] y);
      longint px;
      longint py;
      longint unsigned fr;
      longint unsigned am;
      longint total;
      longint sx;
      longint sy;
      longint s;
      longint i0;
      longint j0;
      longint t;
      longint x0;
      longint y0;
      longint i1;
      longint j1;
      longint n;
      longint g2;
      g2 = UNSKEW_G2;
      px = longint'(x) + seed * 65536;
      py = longint'(y) + seed * 65536;
      fr = frequency;
      am = amplitude;
      total = 0;
      for (int oct = 0; oct < OCTAVES; oct++) begin
        sx = (px * longint'(fr)) >>> 16;
        sy = (py * longint'(fr)) >>> 16;
        s = ((sx + sy) * longint'(SKEW_F2)) >>> 16;
        i0 = (sx + s) >>> 16;
        j0 = (sy + s) >>> 16;
        t = (i0 + j0) * g2;
        x0 = sx - i0 * 65536 + t;
        y0 = sy - j0 * 65536 + t;
        // On a tie the middle corner is (0, 1).
        i1 = (x0 > y0) ? 1 : 0;
        j1 = 1 - i1;
        n = corner_term(i0, j0, x0, y0);
        n += corner_term(i0 + i1, j0 + j1, x0 - i1 * 65536 + g2, y0 - j1 * 65536 + g2);
        n += corner_term(i0 + 1, j0 + 1, x0 - 65536 + 2 * g2, y0 - 65536 + 2 * g2);
        total += (n * longint'(am)) >>> 16;
        fr = (fr * lacunarity) >> 16;
        if (fr > MAX24) fr = MAX24;
        am = (am * persistence) >> 16;
        if (am > MAX24) am = MAX24;
      end
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      return int'(total);
    endfunction

    function void note_sample(logic signed [31:0] x, logic signed [31:0] y);
      expected_noise.push_back(fractal_noise(x, y));
    endfunction

    function void check_noise(logic signed [31:0] actual);
      int exp_v;
      if (expected_noise.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
        errors++;
        return;
      end
      exp_v = expected_noise.pop_front();
      if (exp_v !== actual) begin
        $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time, exp_v, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sn2o_sample_if sample();
  sn2o_result_if result();
  sn2o_cfg_if cfg();

  simplex_noise_2d_octaves dut (
    .clk(clk),
    .rst(rst),
    .sample(sample.sink),
    .result(result.source),
    .cfg(cfg.sink)
  );

  noise_scoreboard sb = new();

  // Receiver behavior, set by the main sequence: probability of stalling in
  // percent, and a count of cycles of forced hold-off.
  int stall_pct = 0;
  int hold_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    sample.valid = 1'b0;
    sample.x_coord = '0;
    sample.y_coord = '0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
  end

  // All handshakes are observed at the rising edge; inputs only ever move at
  // the falling edge, so the values seen here are the settled ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample.valid && sample.ready) sb.note_sample(sample.x_coord, sample.y_coord);
      if (result.valid && result.ready) sb.check_noise(result.noise_value);
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
    end
  end

  // The receiver stalls at random, and on request holds off for a long run
  // of cycles so the pipeline fills and pushes back on the sample input.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      result.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Sender burst state: items left in the current burst.
  int burst_left = 0;

  // Offers one sample request and returns at the falling edge after it was
  // accepted. Valid stays high across a burst and drops only for a gap.
  task automatic send_sample(logic signed [31:0] x, logic signed [31:0] y, bit gaps);
    if (gaps && burst_left == 0) begin
      sample.valid <= 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    sample.valid <= 1'b1;
    sample.x_coord <= x;
    sample.y_coord <= y;
    do @(posedge clk); while (!(sample.valid && sample.ready));
    @(negedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic idle_sender();
    sample.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Waits until every expected result has come back, then lets the pipeline run
  // empty, so that no sample is still in flight.
  task automatic drain();
    idle_sender();
    while (sb.expected_noise.size() != 0) @(negedge clk);
    repeat (NSTG + 8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_regs(logic [23:0] fr, logic [23:0] am, logic [23:0] lac,
                          logic [23:0] pers, logic [23:0] seed);
    drain();
    write_reg(REG_BASE_FREQUENCY, fr);
    write_reg(REG_BASE_AMPLITUDE, am);
    write_reg(REG_LACUNARITY, lac);
    write_reg(REG_PERSISTENCE, pers);
    write_reg(REG_SEED_OFFSET, seed);
  endtask

  // Random coordinate: full range or a few cells around the origin. Diagonal ties,
  // where both cell offsets are equal, come from random_samples.
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(1)) return $urandom();
    return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
  endfunction

  task automatic random_samples(int count);
    logic [31:0] x;
    for (int k = 0; k < count; k++) begin
      x = rand_coord();
      if ($urandom_range(9) == 0) send_sample(x, x, 1'b1);
      else send_sample(x, rand_coord(), 1'b1);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed samples at the reset settings: extremes, the origin, diagonal
    // ties and coordinates far enough out that cell indexes wrap.
    stall_pct = 0;
    send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh80000000, 32'sh80000000, 1'b0);
    send_sample(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
    send_sample(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
    send_sample(0, 0, 1'b0);
    send_sample(32'sh00008000, 32'sh00008000, 1'b0);
    send_sample(32'sh00004000, 32'sh00008000, 1'b0);
    send_sample(32'sh00008000, 32'sh00004000, 1'b0);
    send_sample(32'sh01000000, 32'sh00FF8000, 1'b0);
    send_sample(32'shFFFF0000, 32'sh00010000, 1'b0);
    send_sample(32'sh12345678, 32'shEDCBA987, 1'b0);
    send_sample(-1, -1, 1'b0);

    // Every register at its top value, persistence above one and the largest
    // seed, so amplitude saturates and the output clamps.
    set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h007FFF);
    send_sample(32'sh00012345, 32'sh00054321, 1'b0);
    send_sample(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
    send_sample(32'sh00003000, 32'sh00003000, 1'b0);
    send_sample(32'shC0001234, 32'sh3FFF4321, 1'b0);
    send_sample(0, 32'sh00020000, 1'b0);

    // Everything at zero and the most negative seed; an out-of-range index
    // must be ignored.
    set_regs(24'h0, 24'h0, 24'h0, 24'h0, 24'h008000);
    write_reg(3'd5, 24'hFFFFFF);
    write_reg(3'd7, 24'h5A5A5A);
    send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh00018000, 32'sh00028000, 1'b0);
    set_regs(24'h010000, 24'h400000, 24'h004000, 24'h010000, 24'h008000);
    send_sample(32'sh00018000, 32'sh00028000, 1'b0);
    send_sample(32'sh80000000, 32'sh00000001, 1'b0);

    // Random phases with random settings; the third one also holds the
    // receiver off long enough that the input stalls.
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(24'($urandom_range(0, 4 << 16)), 24'($urandom_range(0, 24'hFFFFFF)),
               (ph == 5) ? 24'($urandom()) : 24'($urandom_range(0, 4 << 16)),
               (ph == 4) ? 24'($urandom()) : 24'($urandom_range(0, 65536)),
               24'($urandom()));
      write_reg(3'($urandom_range(5, 7)), 24'($urandom()));
      stall_pct = (ph == 0) ? 0 : $urandom_range(10, 70);
      if (ph == 2) hold_cycles = 400;
      random_samples(255);
    end

    drain();
    if (sb.expected_noise.size() != 0) begin
      $display("%0t: %0d results missing, expected %0d, actual none", $time,
               sb.expected_noise.size(), sb.expected_noise[0]);
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
